>>> hw/rtl/sclt_pkg.sv
`default_nettype none
package sclt_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CNT_W      = 11;

  localparam logic [2:0] CFG_TABLE_COUNT     = 3'd0;
  localparam logic [2:0] CFG_LEFT_SHIFT      = 3'd1;
  localparam logic [2:0] CFG_RIGHT_SHIFT     = 3'd2;
  localparam logic [2:0] CFG_RETURN          = 3'd3;
  localparam logic [2:0] CFG_SPACE           = 3'd4;
  localparam logic [2:0] CFG_BACKSPACE       = 3'd5;

  localparam logic [7:0] KEY_LSHIFT   = 8'd35;
  localparam logic [7:0] KEY_RSHIFT   = 8'd36;
  localparam logic [7:0] KEY_ENTER    = 8'd45;
  localparam logic [7:0] KEY_SPACEBAR = 8'd43;
  localparam logic [7:0] KEY_ERASE    = 8'd44;

  localparam logic [7:0] CH_NONE      = 8'h00;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic [7:0] REL_BIT = 8'h80;

  localparam logic [1:0] MOD_NONE  = 2'd0;
  localparam logic [1:0] MOD_SHIFT = 2'd1;

  typedef struct packed {
    logic [7:0] code;
    logic [1:0] modifier;
    logic [7:0] ch;
    logic [7:0] key;
  } sclt_entry_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [7:0] key;
    logic [7:0] ch;
  } sclt_search_t;

endpackage
`default_nettype wire

>>> hw/rtl/sclt_search.sv
`default_nettype none
module sclt_search import sclt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int AW      = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire sclt_entry_t       wr_entry,
  input  wire logic [7:0]        sc,
  input  wire logic              shift_any,
  input  wire logic [CNT_W-1:0]  count,
  output sclt_search_t           status
);

  sclt_entry_t      mem [ENTRIES];
  sclt_entry_t      rd_data;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;
  logic             active;
  logic             issue;
  logic             code_hit;
  logic             mod_ok;
  logic             hit;
  logic             exhausted;

  assign issue     = active && (rd_idx < count);
  assign code_hit  = (rd_data.code == sc) ||
                     (({1'b0, rd_data.code} + {1'b0, REL_BIT}) == {1'b0, sc});
  assign mod_ok    = (rd_data.modifier == MOD_NONE) ||
                     ((rd_data.modifier == MOD_SHIFT) && shift_any);
  assign hit       = rd_pend && code_hit && mod_ok;
  assign exhausted = !rd_pend && (rd_idx >= count);

  assign status.done  = active && (hit || exhausted);
  assign status.found = hit;
  assign status.key   = rd_data.key;
  assign status.ch    = rd_data.ch;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      rd_pend <= 1'b0;
      rd_idx  <= '0;
    end else if (start) begin
      active  <= 1'b1;
      rd_pend <= 1'b0;
      rd_idx  <= '0;
    end else if (active) begin
      if (status.done) begin
        active  <= 1'b0;
        rd_pend <= 1'b0;
      end else if (issue) begin
        rd_pend <= 1'b1;
        rd_idx  <= CNT_W'(rd_idx + 1'b1);
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/scancode_layout_translator_unit.sv
// A table write, or a scancode while table_count is zero, passes through ST_DECODE back to ST_IDLE, ready again.
// Shift, return, space and backspace codes go from ST_DECODE straight to ST_EMIT, which raises m_tvalid.
// Other codes scan the layout table one entry per cycle, over min(table_count, ENTRIES) entries; the first
// match goes on to ST_EMIT, and a miss drops the request with no event.
// One request is in work at a time; a stalled m_tready holds the unit in ST_EMIT while an earlier event waits.
// Reset (rst, synchronous) clears the shift flags, the configuration registers and m_tvalid; the table is not cleared.
`default_nettype none
module scancode_layout_translator_unit import sclt_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // scancode[7:0], entry_index[13:8], entry_scancode[21:14],
  // entry_modifier[23:22], entry_char[31:24], entry_key[39:32]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  wire logic                  s_tuser,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // is_release[0], key_code[8:1], character[16:9], left_shift[17],
  // right_shift[18], zero[23:19]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_addr,
  input  wire logic [8:0]            cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]           state;
  logic [6:0]           table_count;
  logic [8:0]           lshift_code;
  logic [8:0]           rshift_code;
  logic [8:0]           return_code;
  logic [8:0]           space_code;
  logic [8:0]           bksp_code;
  logic                 lshift;
  logic                 rshift;
  logic                 req_q;
  logic [IN_DATA_W-1:0] din_q;
  logic                 res_rel;
  logic [7:0]           res_key;
  logic [7:0]           res_ch;

  logic [7:0]           sc;
  logic [CNT_W-1:0]     idx_ext;
  logic [CNT_W-1:0]     tc_ext;
  logic [CNT_W-1:0]     count;
  logic                 in_range;
  logic                 wr_en;
  logic                 start;
  sclt_entry_t          wr_entry;
  sclt_search_t         srch;

  logic                 fix_hit;
  logic [7:0]           fix_key;
  logic [7:0]           fix_ch;
  logic                 lshift_next;
  logic                 rshift_next;

  assign sc       = din_q[7:0];
  assign idx_ext  = CNT_W'(din_q[13:8]);
  assign in_range = idx_ext < ENTRIES_C;
  assign tc_ext   = CNT_W'(table_count);
  assign count    = (tc_ext > ENTRIES_C) ? ENTRIES_C : tc_ext;

  assign wr_entry.code     = din_q[21:14];
  assign wr_entry.modifier = din_q[23:22];
  assign wr_entry.ch       = din_q[31:24];
  assign wr_entry.key      = din_q[39:32];

  assign wr_en    = (state == ST_DECODE) && req_q && in_range;
  assign start    = (state == ST_DECODE) && !req_q && (count != '0) && !fix_hit;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    fix_hit     = 1'b1;
    fix_key     = KEY_LSHIFT;
    fix_ch      = CH_NONE;
    lshift_next = lshift;
    rshift_next = rshift;
    if (!lshift_code[8] && (lshift_code == {1'b0, sc})) begin
      lshift_next = 1'b1;
    end else if (!lshift_code[8] &&
                 (({1'b0, lshift_code} + {2'b0, REL_BIT}) == {2'b0, sc})) begin
      lshift_next = 1'b0;
    end else if (!rshift_code[8] && (rshift_code == {1'b0, sc})) begin
      fix_key     = KEY_RSHIFT;
      rshift_next = 1'b1;
    end else if (!rshift_code[8] &&
                 (({1'b0, rshift_code} + {2'b0, REL_BIT}) == {2'b0, sc})) begin
      fix_key     = KEY_RSHIFT;
      rshift_next = 1'b0;
    end else if (!return_code[8] && (return_code[7:0] == sc)) begin
      fix_key = KEY_ENTER;
      fix_ch  = CH_NEWLINE;
    end else if (!space_code[8] && (space_code[7:0] == sc)) begin
      fix_key = KEY_SPACEBAR;
      fix_ch  = CH_SPACE;
    end else if (!bksp_code[8] && (bksp_code[7:0] == sc)) begin
      fix_key = KEY_ERASE;
      fix_ch  = CH_BACKSPACE;
    end else begin
      fix_hit = 1'b0;
    end
  end

  sclt_search #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .wr_en     (wr_en),
    .wr_addr   (idx_ext[AW-1:0]),
    .wr_entry  (wr_entry),
    .sc        (sc),
    .shift_any (lshift || rshift),
    .count     (count),
    .status    (srch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
      lshift_code <= 9'd256;
      rshift_code <= 9'd256;
      return_code <= 9'd256;
      space_code  <= 9'd256;
      bksp_code   <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TABLE_COUNT: table_count <= cfg_data[6:0];
        CFG_LEFT_SHIFT:  lshift_code <= cfg_data;
        CFG_RIGHT_SHIFT: rshift_code <= cfg_data;
        CFG_RETURN:      return_code <= cfg_data;
        CFG_SPACE:       space_code  <= cfg_data;
        CFG_BACKSPACE:   bksp_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q <= s_tuser;
      din_q <= s_tdata;
    end
    if (state == ST_DECODE) begin
      res_rel <= sc[7];
      res_key <= fix_key;
      res_ch  <= fix_ch;
    end else if (state == ST_SEARCH) begin
      res_key <= srch.key;
      res_ch  <= srch.ch;
    end
    if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'b0, rshift, lshift, res_ch, res_key, res_rel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lshift   <= 1'b0;
      rshift   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (req_q || (count == '0)) begin
            state <= ST_IDLE;
          end else if (fix_hit) begin
            lshift <= lshift_next;
            rshift <= rshift_next;
            state  <= ST_EMIT;
          end else begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch.done) begin
            state <= srch.found ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    srch.done |-> (state == ST_SEARCH))
    else $error("search finished outside the search state");

  a_miss_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) && srch.done && !srch.found |=> (state == ST_IDLE))
    else $error("search miss did not drop the request");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DECODE) |=> ($stable(lshift) && $stable(rshift)))
    else $error("shift flags changed outside decode");
`endif

endmodule
`default_nettype wire

>>> tb/scancode_layout_checker.sv
`timescale 1ns / 100ps
module scancode_layout_checker import sclt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tuser,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_addr,
  input  wire logic [8:0]            cfg_data,
  output int                         mismatch_count,
  output int                         pending_count
);

  localparam int SLOTS = 64;
  localparam logic [8:0] CODE_NONE = 9'd256;

  typedef struct packed {
    logic       right_shift;
    logic       left_shift;
    logic [7:0] character;
    logic [7:0] key_code;
    logic       is_release;
  } key_event_t;

  logic [6:0]  table_count;
  logic [8:0]  left_code;
  logic [8:0]  right_code;
  logic [8:0]  return_code;
  logic [8:0]  space_code;
  logic [8:0]  backspace_code;
  logic        left_held;
  logic        right_held;
  sclt_entry_t layout [SLOTS];
  key_event_t  expected_events [$];
  int          errors = 0;
  int          waiting = 0;

  assign mismatch_count = errors;
  assign pending_count  = waiting;

  function automatic logic translate_code(input logic [7:0] sc, output key_event_t ev);
    logic [8:0] code9;
    logic [6:0] limit;
    logic [7:0] key;
    logic [7:0] ch;
    logic       found;
    int         i;
    code9 = {1'b0, sc};
    limit = (table_count > 7'(SLOTS)) ? 7'(SLOTS) : table_count;
    key   = '0;
    ch    = CH_NONE;
    found = 1'b1;
    ev    = '0;
    if (limit == 7'd0) begin
      return 1'b0;
    end
    if (left_code < CODE_NONE && code9 == left_code) begin
      left_held = 1'b1;
      key = KEY_LSHIFT;
    end else if (left_code < CODE_NONE && code9 == left_code + 9'(REL_BIT)) begin
      left_held = 1'b0;
      key = KEY_LSHIFT;
    end else if (right_code < CODE_NONE && code9 == right_code) begin
      right_held = 1'b1;
      key = KEY_RSHIFT;
    end else if (right_code < CODE_NONE && code9 == right_code + 9'(REL_BIT)) begin
      right_held = 1'b0;
      key = KEY_RSHIFT;
    end else if (return_code < CODE_NONE && code9 == return_code) begin
      key = KEY_ENTER;
      ch  = CH_NEWLINE;
    end else if (space_code < CODE_NONE && code9 == space_code) begin
      key = KEY_SPACEBAR;
      ch  = CH_SPACE;
    end else if (backspace_code < CODE_NONE && code9 == backspace_code) begin
      key = KEY_ERASE;
      ch  = CH_BACKSPACE;
    end else begin
      found = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
        if (!found && i < int'(limit) &&
            (layout[i].code == sc || {1'b0, layout[i].code} + 9'(REL_BIT) == code9)) begin
          if (layout[i].modifier == MOD_NONE ||
              (layout[i].modifier == MOD_SHIFT && (left_held || right_held))) begin
            found = 1'b1;
            key = layout[i].key;
            ch  = layout[i].ch;
          end
        end
      end
    end
    ev.is_release  = sc[7];
    ev.key_code    = key;
    ev.character   = ch;
    ev.left_shift  = left_held;
    ev.right_shift = right_held;
    return found;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    key_event_t got;
    key_event_t want;
    key_event_t predicted;
    if (rst) begin
      table_count    = '0;
      left_code      = CODE_NONE;
      right_code     = CODE_NONE;
      return_code    = CODE_NONE;
      space_code     = CODE_NONE;
      backspace_code = CODE_NONE;
      left_held      = 1'b0;
      right_held     = 1'b0;
      expected_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[18:0];
        if (expected_events.size() == 0) begin
          errors++;
          $error("unexpected event: tdata %h", m_tdata);
        end else begin
          want = expected_events.pop_front();
          check_field("is_release", 8'(want.is_release), 8'(got.is_release));
          check_field("key_code", want.key_code, got.key_code);
          check_field("character", want.character, got.character);
          check_field("left_shift", 8'(want.left_shift), 8'(got.left_shift));
          check_field("right_shift", 8'(want.right_shift), 8'(got.right_shift));
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TABLE_COUNT: table_count    = cfg_data[6:0];
          CFG_LEFT_SHIFT:  left_code      = cfg_data;
          CFG_RIGHT_SHIFT: right_code     = cfg_data;
          CFG_RETURN:      return_code    = cfg_data;
          CFG_SPACE:       space_code     = cfg_data;
          CFG_BACKSPACE:   backspace_code = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          layout[s_tdata[13:8]] = {s_tdata[21:14], s_tdata[23:22], s_tdata[31:24],
                                   s_tdata[39:32]};
        end else if (translate_code(s_tdata[7:0], predicted)) begin
          expected_events = {expected_events, predicted};
        end
      end
    end
    waiting = expected_events.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import sclt_pkg::*;

  localparam logic       REQ_TRANSLATE   = 1'b0;
  localparam logic       REQ_TABLE_WRITE = 1'b1;
  localparam logic [1:0] MOD_OTHER       = 2'd2;
  localparam logic [1:0] MOD_RESERVED    = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO    = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI    = 3'd7;
  localparam logic [8:0] CODE_NONE       = 9'd256;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int ITEMS_PER_STEP = 70;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [2:0]            cfg_addr;
  logic [8:0]            cfg_data;
  int                    mismatch_count;
  int                    pending_count;

  int         send_idle;
  int         recv_idle;
  int         cycles = 0;
  logic [7:0] slot_code [64];
  logic [8:0] cur_code [5];

  scancode_layout_translator_unit uut (.*);
  scancode_layout_checker monitor (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("scancode_layout_translator_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic kind, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= data;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_scancode(input logic [7:0] sc);
    send_request(REQ_TRANSLATE, {$urandom(), sc});
  endtask

  task automatic write_entry(input logic [5:0] slot, input logic [7:0] code,
                             input logic [1:0] modifier, input logic [7:0] ch,
                             input logic [7:0] key);
    slot_code[slot] = code;
    send_request(REQ_TABLE_WRITE, {key, ch, modifier, code, slot, 8'($urandom())});
  endtask

  // hold until every event has drained and the search has had time to finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [8:0] value);
    cfg_addr <= addr;
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [8:0] count, input logic [8:0] ls,
                                input logic [8:0] rs, input logic [8:0] ret,
                                input logic [8:0] sp, input logic [8:0] bs);
    cur_code[0] = ls;
    cur_code[1] = rs;
    cur_code[2] = ret;
    cur_code[3] = sp;
    cur_code[4] = bs;
    settle();
    write_reg(CFG_TABLE_COUNT, count);
    write_reg(CFG_LEFT_SHIFT, ls);
    write_reg(CFG_RIGHT_SHIFT, rs);
    write_reg(CFG_RETURN, ret);
    write_reg(CFG_SPACE, sp);
    write_reg(CFG_BACKSPACE, bs);
    write_reg(CFG_SPARE_LO, 9'($urandom()));
    write_reg(CFG_SPARE_HI, 9'($urandom()));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] entry_code_pick();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [8:0] random_code();
    return ($urandom_range(0, 9) == 0) ? CODE_NONE : 9'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] scancode_pick();
    logic [7:0] sc;
    case ($urandom_range(0, 9))
      0, 1: sc = cur_code[$urandom_range(0, 4)][7:0];
      2: sc = cur_code[$urandom_range(0, 4)][7:0] + REL_BIT;
      3, 4, 5, 6: begin
        sc = slot_code[$urandom_range(0, 63)];
        if ($urandom_range(0, 1)) sc = sc | REL_BIT;
      end
      default: sc = 8'($urandom_range(0, 255));
    endcase
    return sc;
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 99) < 15) begin
      write_entry(6'($urandom_range(0, 63)), entry_code_pick(), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      send_scancode(scancode_pick());
    end
  endtask

  initial begin
    logic [7:0] probe [19];
    probe     = '{8'h10, 8'h90, 8'h2A, 8'h10, 8'h36, 8'hAA, 8'h10, 8'hB6,
                  8'h11, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h1C, 8'h9C, 8'h39,
                  8'h0E, 8'h55, 8'h12};
    clk       = 1'b0;
    rst       = 1'b1;
    s_tdata   = '0;
    s_tuser   = REQ_TRANSLATE;
    s_tvalid  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_TABLE_COUNT;
    cfg_data  = '0;
    send_idle = 9;
    recv_idle = 47;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table: shift and fixed codes must do nothing
    apply_settings(9'd0, 9'h02A, 9'h036, 9'h01C, 9'h039, 9'h00E);
    send_scancode(8'h2A);
    send_scancode(8'h1C);
    send_scancode(8'hAA);

    write_entry(6'd0, 8'h10, MOD_SHIFT, 8'h51, 8'd1);
    write_entry(6'd1, 8'h10, MOD_NONE, 8'h71, 8'd2);
    write_entry(6'd2, 8'h11, MOD_OTHER, 8'h41, 8'd3);
    write_entry(6'd3, 8'h11, MOD_RESERVED, 8'h42, 8'd4);
    write_entry(6'd4, 8'h00, MOD_NONE, 8'h00, 8'h00);
    write_entry(6'd5, 8'hFF, MOD_NONE, 8'hFF, 8'hFF);
    write_entry(6'd6, 8'h2A, MOD_NONE, 8'h61, 8'd7);
    write_entry(6'd7, 8'h12, MOD_NONE, 8'h62, 8'd8);

    apply_settings(9'd8, 9'h02A, 9'h036, 9'h01C, 9'h039, 9'h00E);
    foreach (probe[i]) send_scancode(probe[i]);
    write_entry(6'd7, 8'h12, MOD_SHIFT, 8'h63, 8'd9);
    send_scancode(8'h12);

    for (int slot = 8; slot < 64; slot++) begin
      write_entry(6'(slot), entry_code_pick(), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    for (int step = 0; step < 6; step++) begin
      if (step == 2) begin
        send_idle = 47;
        recv_idle = 9;
      end else if (step == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (step)
        0: apply_settings(9'd64, 9'h02A, 9'h036, 9'h01C, 9'h039, 9'h00E);
        1: apply_settings(9'd127, 9'h000, 9'h0FF, 9'h100, 9'h1FF, 9'h080);
        2: apply_settings(9'd1, 9'h07F, 9'h0C0, 9'h0FF, 9'h000, 9'h001);
        3: apply_settings(9'($urandom_range(2, 63)), random_code(), random_code(),
                          random_code(), random_code(), random_code());
        4: apply_settings(9'd0, random_code(), random_code(), random_code(),
                          random_code(), random_code());
        default: apply_settings(9'($urandom_range(1, 64)), random_code(), random_code(),
                                random_code(), random_code(), random_code());
      endcase
      repeat (ITEMS_PER_STEP) random_item();
    end

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("scancode_layout_translator_unit: match");
    end else begin
      $display("scancode_layout_translator_unit: mismatch");
    end
    $finish;
  end

endmodule
